FILE: sv/imapas_pkg.sv
// ----------------------------------------------------------------------------
// imapas_pkg
// shared types, codes and byte classification for the astring parser
// ----------------------------------------------------------------------------
package imapas_pkg;

    // literal byte counter and its widened accumulate value
    localparam int COUNT_W = 32;
    localparam int WIDE_W  = COUNT_W + 4;
    localparam int CFG_W   = 32;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // astring forms
    localparam logic [1:0] FORM_ATOM    = 2'd0;
    localparam logic [1:0] FORM_QUOTED  = 2'd1;
    localparam logic [1:0] FORM_LITERAL = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       forbid_first;
        logic       atom_end;
        logic       quoted_bad;
        logic       is_ws;
        logic       is_quote;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_bslash;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        logic        ws;
        logic        paren;
        logic [7:0]  dv;
        ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
        paren = (b == CH_LPAREN) || (b == CH_RPAREN);
        dv    = b - CH_ZERO;
        c.data         = b;
        c.forbid_first = (b == CH_NUL) || (b == CH_SPACE) || paren ||
                         (b == CH_CR) || (b == CH_LF);
        c.atom_end     = (b == CH_NUL) || ws || paren || (b == CH_DQUOTE);
        c.quoted_bad   = (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);
        c.is_ws        = ws;
        c.is_quote     = (b == CH_DQUOTE);
        c.is_lbrace    = (b == CH_LBRACE);
        c.is_rbrace    = (b == CH_RBRACE);
        c.is_bslash    = (b == CH_BSLASH);
        c.is_cr        = (b == CH_CR);
        c.is_lf        = (b == CH_LF);
        c.is_digit     = (b >= CH_ZERO) && (b <= CH_NINE);
        c.digit        = dv[3:0];
        return c;
    endfunction

endpackage

FILE: sv/imapas_front.sv
// ----------------------------------------------------------------------------
// imapas_front
// input stage: takes a byte request and registers its classification
// ----------------------------------------------------------------------------
module imapas_front
    import imapas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    output logic        out_valid,
    input  logic        out_ready,
    output byte_class_t out_item
);

    logic        valid_reg;
    logic        valid_next;
    byte_class_t item_reg;

    assign s_tready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= classify(s_tdata);
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: sv/imapas_fifo.sv
// ----------------------------------------------------------------------------
// imapas_fifo
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module imapas_fifo
    import imapas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  byte_class_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output byte_class_t pop_item
);

    byte_class_t        mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   level_reg;
    logic [FIFO_AW:0]   level_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (level_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/imapas_back.sv
// ----------------------------------------------------------------------------
// imapas_back
// parse state machine and output register
// ----------------------------------------------------------------------------
module imapas_back
    import imapas_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  byte_class_t      in_item,
    input  logic [CFG_W-1:0] max_len,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [1:0]       res_kind,
    output logic [7:0]       res_byte,
    output logic [1:0]       res_form
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ATOM    = 4'd1;
    localparam logic [3:0] PH_QUOTED  = 4'd2;
    localparam logic [3:0] PH_QESC    = 4'd3;
    localparam logic [3:0] PH_QAFTER  = 4'd4;
    localparam logic [3:0] PH_LDIGITS = 4'd5;
    localparam logic [3:0] PH_LCR     = 4'd6;
    localparam logic [3:0] PH_LLF     = 4'd7;
    localparam logic [3:0] PH_LDATA   = 4'd8;
    localparam logic [3:0] PH_LAFTER  = 4'd9;

    logic [3:0]         phase_reg;
    logic [3:0]         phase_next;
    logic [1:0]         form_reg;
    logic [1:0]         form_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               saw_digit_reg;
    logic               saw_digit_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic [7:0]         byte_reg;
    logic [1:0]         oform_reg;

    logic               fire;
    logic               emit;
    logic [1:0]         emit_kind;
    logic [1:0]         emit_form;
    logic [WIDE_W-1:0]  count_wide;
    logic [WIDE_W-1:0]  accum;
    logic               too_long;
    logic [COUNT_W-1:0] count_dec;

    assign in_ready = !out_valid_reg || m_tready;
    assign fire     = in_valid && in_ready;

    // count * 10 + digit as shift-add, overflow seen in the top bits
    assign count_wide = {{(WIDE_W-COUNT_W){1'b0}}, count_reg};
    assign accum      = (count_wide << 3) + (count_wide << 1) + WIDE_W'(in_item.digit);
    assign too_long   = (accum[WIDE_W-1:COUNT_W] != '0) || (accum > WIDE_W'(max_len));
    assign count_dec  = count_reg - 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        form_next      = form_reg;
        count_next     = count_reg;
        saw_digit_next = saw_digit_reg;
        emit           = 1'b0;
        emit_kind      = KIND_CONTENT;
        emit_form      = form_reg;
        case (phase_reg)
            PH_IDLE: begin
                emit_form = FORM_ATOM;
                if (in_item.forbid_first) begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end else if (in_item.is_quote) begin
                    phase_next = PH_QUOTED;
                    form_next  = FORM_QUOTED;
                end else if (in_item.is_lbrace) begin
                    phase_next     = PH_LDIGITS;
                    form_next      = FORM_LITERAL;
                    count_next     = '0;
                    saw_digit_next = 1'b0;
                end else if (in_item.is_ws) begin
                    emit      = 1'b1;
                    emit_kind = KIND_DONE;
                end else begin
                    phase_next = PH_ATOM;
                    emit       = 1'b1;
                end
            end
            PH_ATOM: begin
                emit = 1'b1;
                if (in_item.atom_end) begin
                    emit_kind = KIND_DONE;
                end
            end
            PH_QUOTED: begin
                if (in_item.is_bslash) begin
                    phase_next = PH_QESC;
                end else if (in_item.is_quote) begin
                    phase_next = PH_QAFTER;
                end else if (in_item.quoted_bad) begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_QESC: begin
                phase_next = PH_QUOTED;
                emit       = 1'b1;
            end
            PH_QAFTER, PH_LAFTER: begin
                emit      = 1'b1;
                emit_kind = KIND_DONE;
            end
            PH_LDIGITS: begin
                if (in_item.is_digit) begin
                    if (too_long) begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                    end else begin
                        count_next     = accum[COUNT_W-1:0];
                        saw_digit_next = 1'b1;
                    end
                end else if (saw_digit_reg && in_item.is_rbrace) begin
                    phase_next = PH_LCR;
                end else begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end
            end
            PH_LCR: begin
                if (in_item.is_cr) begin
                    phase_next = PH_LLF;
                end else begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end
            end
            PH_LLF: begin
                if (in_item.is_lf) begin
                    phase_next = (count_reg == '0) ? PH_LAFTER : PH_LDATA;
                end else begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end
            end
            PH_LDATA: begin
                emit       = 1'b1;
                count_next = count_dec;
                if (count_dec == '0) begin
                    phase_next = PH_LAFTER;
                end
            end
            default: begin
                emit      = 1'b1;
                emit_kind = KIND_ERROR;
            end
        endcase
        // completion and error both drop back to idle
        if (emit && (emit_kind != KIND_CONTENT)) begin
            phase_next     = PH_IDLE;
            form_next      = FORM_ATOM;
            count_next     = '0;
            saw_digit_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            form_reg      <= FORM_ATOM;
            count_reg     <= '0;
            saw_digit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                phase_reg     <= phase_next;
                form_reg      <= form_next;
                count_reg     <= count_next;
                saw_digit_reg <= saw_digit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            kind_reg  <= emit_kind;
            byte_reg  <= in_item.data;
            oform_reg <= emit_form;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign res_kind = kind_reg;
    assign res_byte = byte_reg;
    assign res_form = oform_reg;

endmodule

FILE: sv/imap_astring_parser.sv
// ----------------------------------------------------------------------------
// imap_astring_parser
// byte-stream parser for one imap astring at a time
// ----------------------------------------------------------------------------
// Bytes come in on the s_ stream, one per request, and the parser turns
// each astring (atom, quoted string or {n} literal) into content-byte
// results followed by one completion result that carries the byte after
// the astring; a malformed byte gives an error result instead, and either
// way the parser is idle again for the next astring. Throughput is one
// byte per clock, sustained while m_tready stays high, set by the parse
// state update in the back end (including the decimal count accumulate
// of a literal header); a byte passes from s_ to m_ through the input
// register, the queue and the output register. Bytes that produce no
// result (opening quote, brace, header digits, CR, LF, escape backslash)
// are consumed without a gap.
// cfg_wr_data written with cfg_wr_en sets the largest literal count taken;
// write it only while the parser has no bytes in flight.
// ----------------------------------------------------------------------------
module imap_astring_parser
    import imapas_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: max literal length
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // input bytes
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] in_byte
    // results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [3:0]       m_tuser    // [1:0] out_kind, [3:2] form
);

    // max literal length, all ones after reset
    logic [CFG_W-1:0] max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= '1;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // front stage to queue
    logic        front_valid;
    logic        front_ready;
    byte_class_t front_item;

    // queue to back end
    logic        q_valid;
    logic        q_ready;
    byte_class_t q_item;

    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic [1:0]  res_form;

    // classify each byte request and register it
    imapas_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // decouples input stalls from output stalls
    imapas_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // parse state machine, drives the result register
    imapas_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .max_len  (max_len_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_kind (res_kind),
        .res_byte (res_byte),
        .res_form (res_form)
    );

    assign m_tdata = res_byte;
    assign m_tuser = {res_form, res_kind};

    // result kind is never the unused code
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == KIND_CONTENT || m_tuser[1:0] == KIND_DONE ||
                      m_tuser[1:0] == KIND_ERROR))
        else $error("illegal result kind");

    // an error inside a quoted string comes only from nul, cr or lf
    a_quoted_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == KIND_ERROR && m_tuser[3:2] == FORM_QUOTED) |->
        (m_tdata == CH_NUL || m_tdata == CH_CR || m_tdata == CH_LF))
        else $error("quoted error on a legal byte");

    // an atom completion carries an atom delimiter
    a_atom_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == KIND_DONE && m_tuser[3:2] == FORM_ATOM) |->
        (m_tdata == CH_NUL || m_tdata == CH_SPACE || m_tdata == CH_TAB ||
         m_tdata == CH_LF || m_tdata == CH_VT || m_tdata == CH_FF ||
         m_tdata == CH_CR || m_tdata == CH_LPAREN || m_tdata == CH_RPAREN ||
         m_tdata == CH_DQUOTE))
        else $error("atom completed on a non-delimiter");

    // no result directly out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

FILE: tb/tb_imap_astring_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imap_astring_parser
// stream-level check of the astring parser against an in-bench predictor
// ----------------------------------------------------------------------------
// Bytes are pushed in one request at a time. Each accepted byte is also run
// through a cycle-free predictor of the parse state, which queues the result
// that byte should cause. Every result taken off the m_ side is matched
// field by field against the oldest queued one. A directed pass walks the
// three forms and their corner cases, a second one the literal length limit
// and counter overflow. Random astring streams follow, under three
// backpressure mixes and three limit settings.
// ----------------------------------------------------------------------------
module tb_imap_astring_parser;
    import imapas_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [63:0] COUNT_CEIL = (64'd1 << COUNT_W) - 64'd1;

    // parse phases as the predictor tracks them
    typedef enum logic [3:0] {
        P_IDLE, P_ATOM, P_QUOTED, P_QESC, P_QAFTER,
        P_LDIGITS, P_LCR, P_LLF, P_LDATA, P_LAFTER
    } parse_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] form;
    } parse_result_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = '0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [7:0]       m_tdata;
    logic [3:0]       m_tuser;

    // predictor state
    parse_phase_t ph           = P_IDLE;
    logic [1:0]   held_form    = FORM_ATOM;
    logic [63:0]  lit_count    = '0;
    logic         seen_digit   = 1'b0;
    logic [31:0]  max_lit_len  = 32'hFFFF_FFFF;

    parse_result_t pending_results[$];

    int src_gap_pct  = 20;
    int sink_gap_pct = 64;
    int bytes_sent   = 0;
    int fail_count   = 0;
    int idle_cycles  = 0;

    imap_astring_parser dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),      // [7:0] in_byte
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),      // [7:0] out_byte
        .m_tuser    (m_tuser)       // [1:0] out_kind, [3:2] form
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // byte classes
    // ------------------------------------------------------------------
    function automatic bit is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
               b == CH_FF || b == CH_CR;
    endfunction

    // bytes that end an atom
    function automatic bit atom_stop(input logic [7:0] b);
        return b == CH_NUL || is_ws(b) || b == CH_LPAREN || b == CH_RPAREN ||
               b == CH_DQUOTE;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // predictor: one accepted byte in, zero or one result queued
    // ------------------------------------------------------------------
    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [1:0] form);
        parse_result_t r;
        r.kind = kind;
        r.data = b;
        r.form = form;
        pending_results.push_back(r);
    endfunction

    // completion or error: report the held form, then back to idle
    function automatic void close_astring(input logic [1:0] kind, input logic [7:0] b);
        queue_result(kind, b, held_form);
        ph         = P_IDLE;
        held_form  = FORM_ATOM;
        lit_count  = '0;
        seen_digit = 1'b0;
    endfunction

    function automatic void advance_parser(input logic [7:0] b);
        logic [63:0] next_count;
        case (ph)
            P_IDLE: begin
                held_form  = FORM_ATOM;
                lit_count  = '0;
                seen_digit = 1'b0;
                if (b == CH_NUL || b == CH_SPACE || b == CH_LPAREN || b == CH_RPAREN ||
                    b == CH_CR || b == CH_LF) begin
                    close_astring(KIND_ERROR, b);
                end else if (b == CH_DQUOTE) begin
                    held_form = FORM_QUOTED;
                    ph        = P_QUOTED;
                end else if (b == CH_LBRACE) begin
                    held_form = FORM_LITERAL;
                    ph        = P_LDIGITS;
                end else if (is_ws(b)) begin
                    // tab, vt or ff first: empty atom
                    close_astring(KIND_DONE, b);
                end else begin
                    ph = P_ATOM;
                    queue_result(KIND_CONTENT, b, FORM_ATOM);
                end
            end
            P_ATOM: begin
                if (atom_stop(b)) close_astring(KIND_DONE, b);
                else queue_result(KIND_CONTENT, b, FORM_ATOM);
            end
            P_QUOTED: begin
                if (b == CH_BSLASH) ph = P_QESC;
                else if (b == CH_DQUOTE) ph = P_QAFTER;
                else if (b == CH_NUL || b == CH_CR || b == CH_LF) close_astring(KIND_ERROR, b);
                else queue_result(KIND_CONTENT, b, FORM_QUOTED);
            end
            P_QESC: begin
                ph = P_QUOTED;
                queue_result(KIND_CONTENT, b, FORM_QUOTED);
            end
            P_QAFTER, P_LAFTER: begin
                close_astring(KIND_DONE, b);
            end
            P_LDIGITS: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    next_count = lit_count * 64'd10 + 64'(b - CH_ZERO);
                    if (next_count > COUNT_CEIL || next_count > 64'(max_lit_len)) begin
                        close_astring(KIND_ERROR, b);
                    end else begin
                        lit_count  = next_count;
                        seen_digit = 1'b1;
                    end
                end else if (seen_digit && b == CH_RBRACE) begin
                    ph = P_LCR;
                end else begin
                    close_astring(KIND_ERROR, b);
                end
            end
            P_LCR: begin
                if (b == CH_CR) ph = P_LLF;
                else close_astring(KIND_ERROR, b);
            end
            P_LLF: begin
                if (b == CH_LF) ph = (lit_count == 0) ? P_LAFTER : P_LDATA;
                else close_astring(KIND_ERROR, b);
            end
            P_LDATA: begin
                lit_count = lit_count - 64'd1;
                if (lit_count == 0) ph = P_LAFTER;
                queue_result(KIND_CONTENT, b, FORM_LITERAL);
            end
            default: begin
                close_astring(KIND_ERROR, b);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // one byte request; called and returns at a rising edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        advance_parser(b);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    // wait for every queued result, let header bytes still in flight settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_len(input logic [31:0] limit);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        max_lit_len  = limit;
    endtask

    // brings the parser back to idle whatever phase it was left in
    task automatic resync();
        while (ph != P_IDLE) begin
            if (ph == P_LDATA || ph == P_QESC || ph == P_QAFTER || ph == P_LAFTER)
                send_byte(rand_byte());
            else
                send_byte(CH_CR);
        end
    endtask

    function automatic logic [7:0] atom_terminator();
        case ($urandom_range(9))
            0: return CH_NUL;
            1: return CH_SPACE;
            2: return CH_TAB;
            3: return CH_LF;
            4: return CH_VT;
            5: return CH_FF;
            6: return CH_CR;
            7: return CH_LPAREN;
            8: return CH_RPAREN;
            default: return CH_DQUOTE;
        endcase
    endfunction

    // mostly well-formed astrings with random content, some broken ones
    task automatic send_random_astring();
        int          sel;
        int          n;
        int          count;
        string       digits;
        logic [7:0]  b;
        sel = $urandom_range(99);
        if (sel < 35) begin
            // atom
            do b = rand_byte(); while (atom_stop(b) || b == CH_LBRACE);
            send_byte(b);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do b = rand_byte(); while (atom_stop(b));
                send_byte(b);
            end
            send_byte(atom_terminator());
        end else if (sel < 65) begin
            // quoted string, some escapes
            send_byte(CH_DQUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(99) < 15) begin
                    send_byte(CH_BSLASH);
                    send_byte(rand_byte());
                end else begin
                    do b = rand_byte();
                    while (b == CH_NUL || b == CH_CR || b == CH_LF || b == CH_DQUOTE ||
                           b == CH_BSLASH);
                    send_byte(b);
                end
            end
            if ($urandom_range(99) < 10) begin
                case ($urandom_range(2))
                    0: send_byte(CH_NUL);
                    1: send_byte(CH_CR);
                    default: send_byte(CH_LF);
                endcase
            end else begin
                send_byte(CH_DQUOTE);
                send_byte(rand_byte());
            end
        end else if (sel < 90) begin
            send_byte(CH_LBRACE);
            if ($urandom_range(99) < 10) begin
                // long count: overflow or over the limit, else cut off by a letter
                n = $urandom_range(9, 12);
                for (int k = 0; k < n && ph == P_LDIGITS; k++)
                    send_byte(CH_ZERO + 8'(k == 0 ? $urandom_range(1, 9) : $urandom_range(9)));
                if (ph == P_LDIGITS) send_byte(8'($urandom_range(8'h61, 8'h7A)));
            end else begin
                // missing digits now and then
                if ($urandom_range(99) >= 8) begin
                    count  = $urandom_range(0, 6);
                    digits = $sformatf("%0d", count);
                    for (int k = 0; k < digits.len() && ph == P_LDIGITS; k++)
                        send_byte(digits[k]);
                end
                if (ph == P_LDIGITS)
                    send_byte($urandom_range(99) < 8 ? rand_byte() : CH_RBRACE);
                if (ph == P_LCR)
                    send_byte($urandom_range(99) < 5 ? rand_byte() : CH_CR);
                if (ph == P_LLF)
                    send_byte($urandom_range(99) < 5 ? rand_byte() : CH_LF);
                while (ph == P_LDATA) send_byte(rand_byte());
                if (ph == P_LAFTER) send_byte(rand_byte());
            end
        end else begin
            // stray byte
            send_byte(rand_byte());
        end
        resync();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_forms();
        // atom with top byte value, ended by vertical tab
        send_text("a");
        send_byte(8'hFF);
        send_byte(CH_VT);
        // form feed first: empty atom
        send_byte(CH_FF);
        // nul first is refused
        send_byte(CH_NUL);
        // quoted: escaped nul, closing quote, then a quote as completion byte
        send_byte(CH_DQUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        send_text("q\"\"");
        // bare cr inside a quoted string
        send_byte(CH_DQUOTE);
        send_byte(CH_CR);
        // one-byte literal ended by an open paren
        send_text("{1}");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h80);
        send_byte(CH_LPAREN);
        // empty literal
        send_text("{0}");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_RPAREN);
        // brace with no digits
        send_text("{}");
    endtask

    task automatic test_literal_limits();
        // limit zero: only an empty literal passes
        set_max_len(32'd0);
        send_text("{0}");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("Z{1");
        // small limit, hit exactly and then passed on the second digit
        set_max_len(32'd3);
        send_text("{3}");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("ab\\ {12");
        // full limit: largest count taken, next one overflows the counter
        set_max_len(32'hFFFF_FFFF);
        send_text("{4294967295x{4294967296");
    endtask

    task automatic test_random_stream(input int src_pct, input int sink_pct,
                                      input logic [31:0] limit, input int n_bytes);
        int goal;
        set_max_len(limit);
        src_gap_pct  = src_pct;
        sink_gap_pct = sink_pct;
        goal         = bytes_sent + n_bytes;
        while (bytes_sent < goal) send_random_astring();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_gap_pct);
    end

    // each result against the oldest queued one
    always @(posedge aclk) begin : result_check
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d byte %02h form %0d",
                         $time, m_tuser[1:0], m_tdata, m_tuser[3:2]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[1:0] != want.kind) begin
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, want.kind, m_tuser[1:0]);
                    fail_count++;
                end
                if (m_tdata != want.data) begin
                    $display("%0t: byte mismatch, expected %02h, got %02h",
                             $time, want.data, m_tdata);
                    fail_count++;
                end
                if (m_tuser[3:2] != want.form) begin
                    $display("%0t: form mismatch, expected %0d, got %0d",
                             $time, want.form, m_tuser[3:2]);
                    fail_count++;
                end
            end
        end
    end

    // stall guard: too long with no request taken on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_imap_astring_parser: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_forms();
        test_literal_limits();
        test_random_stream(20, 64, 32'($urandom_range(2, 9)), 490);
        test_random_stream(64, 20, 32'd0, 490);
        test_random_stream(0, 0, 32'hFFFF_FFFF, 490);

        drain();
        if (fail_count == 0) begin
            $display("tb_imap_astring_parser: clean");
        end else begin
            $display("tb_imap_astring_parser: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/imapas_pkg.sv
sv/imapas_front.sv
sv/imapas_fifo.sv
sv/imapas_back.sv
sv/imap_astring_parser.sv
tb/tb_imap_astring_parser.sv
